// ----- hdl/cps_pkg.sv -----
// Shared constants and types for the closest point on segment unit.
package cps_pkg;

    localparam int COORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CLAMP_INTERIOR = 2'd0,
        CLAMP_START    = 2'd1,
        CLAMP_END      = 2'd2,
        CLAMP_DEGEN    = 2'd3
    } clamp_code_t;

endpackage

// ----- hdl/closest_point_on_segment_unit.sv -----
// Pipelined closest point on a 3D segment, signed fixed point coordinates.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_start_*, s_end_*,   | in
//          | s_query_*                               |
//  result  | m_valid, m_ready, m_near_*, m_clamp_code| out
//
// Six arithmetic stages, one stage per quotient bit in the restoring
// divider and the output register; the divider stages set the depth.
// One item is accepted per cycle unless the full pipeline stalls.
// Reset (aresetn, synchronous, active low) clears only the valid bits.
// Each stage holds while the stage after it is full and stalled, so an
// empty stage still takes an item even when the result is not taken.
module closest_point_on_segment_unit
    import cps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_start_z,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic signed [COORD_BITS-1:0] s_end_z,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    input  logic signed [COORD_BITS-1:0] s_query_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_near_x,
    output logic signed [COORD_BITS-1:0] m_near_y,
    output logic signed [COORD_BITS-1:0] m_near_z,
    output logic [1:0]                   m_clamp_code
);

    localparam int W   = COORD_BITS;
    localparam int DW  = W + 1;          // difference width
    localparam int PW  = 2 * DW;         // product width
    localparam int LW  = 2 * W + 2;      // squared length width
    localparam int KW  = LW + 2;         // signed dot product width
    localparam int NW  = 3 * W + 3;      // dividend width
    localparam int NS  = W + 7;          // number of pipeline stages
    localparam int DIV = 6;              // first divider step stage

    // Stage valid bits and per-stage load enables.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    assign en[NS] = m_ready;
    for (genvar g = 0; g < NS; g++) begin : g_en
        assign en[g] = ~vld_reg[g] | en[g+1];
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    logic signed [W-1:0] a_in [3];
    logic signed [W-1:0] b_in [3];
    logic signed [W-1:0] p_in [3];

    assign a_in[0] = s_start_x;
    assign a_in[1] = s_start_y;
    assign a_in[2] = s_start_z;
    assign b_in[0] = s_end_x;
    assign b_in[1] = s_end_y;
    assign b_in[2] = s_end_z;
    assign p_in[0] = s_query_x;
    assign p_in[1] = s_query_y;
    assign p_in[2] = s_query_z;

    // Stage 0: differences D = B - A and V = P - A.
    logic signed [W-1:0]  a0_reg [3];
    logic signed [W-1:0]  b0_reg [3];
    logic signed [DW-1:0] d0_reg [3];
    logic signed [DW-1:0] v0_reg [3];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                a0_reg[i] <= a_in[i];
                b0_reg[i] <= b_in[i];
                d0_reg[i] <= DW'(b_in[i]) - DW'(a_in[i]);
                v0_reg[i] <= DW'(p_in[i]) - DW'(a_in[i]);
            end
        end
    end

    // Stage 1: D.V and D.D terms, one multiplier each.
    logic signed [W-1:0]  a1_reg  [3];
    logic signed [W-1:0]  b1_reg  [3];
    logic signed [DW-1:0] d1_reg  [3];
    logic signed [PW-1:0] dv1_reg [3];
    logic signed [PW-1:0] dd1_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i]  <= a0_reg[i];
                b1_reg[i]  <= b0_reg[i];
                d1_reg[i]  <= d0_reg[i];
                dv1_reg[i] <= d0_reg[i] * v0_reg[i];
                dd1_reg[i] <= d0_reg[i] * d0_reg[i];
            end
        end
    end

    // Stage 2: dot product k and squared length L.
    logic signed [W-1:0]  a2_reg [3];
    logic signed [W-1:0]  b2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [KW-1:0] k2_reg;
    logic [LW-1:0]        l2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
            k2_reg <= KW'(dv1_reg[0]) + KW'(dv1_reg[1]) + KW'(dv1_reg[2]);
            l2_reg <= LW'(dd1_reg[0]) + LW'(dd1_reg[1]) + LW'(dd1_reg[2]);
        end
    end

    // Stage 3: classify and take magnitudes.
    clamp_code_t         code3_next;
    logic signed [KW-1:0] l2_ext;

    assign l2_ext = $signed({2'b00, l2_reg});

    always_comb begin
        priority if (l2_reg == '0) begin
            code3_next = CLAMP_DEGEN;
        end else if (k2_reg <= 0) begin
            code3_next = CLAMP_START;
        end else if (k2_reg >= l2_ext) begin
            code3_next = CLAMP_END;
        end else begin
            code3_next = CLAMP_INTERIOR;
        end
    end

    logic signed [W-1:0] a3_reg    [3];
    logic signed [W-1:0] b3_reg    [3];
    logic [DW-1:0]       dmag3_reg [3];
    logic [2:0]          dneg3_reg;
    logic [LW-1:0]       kmag3_reg;
    logic [LW-1:0]       l3_reg;
    clamp_code_t         code3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                a3_reg[i]    <= a2_reg[i];
                b3_reg[i]    <= b2_reg[i];
                dneg3_reg[i] <= d2_reg[i][DW-1];
                dmag3_reg[i] <= d2_reg[i][DW-1] ? DW'(-d2_reg[i]) : DW'(d2_reg[i]);
            end
            kmag3_reg <= k2_reg[LW-1:0];
            l3_reg    <= l2_reg;
            code3_reg <= code3_next;
        end
    end

    // Stage 4: k * |D| as two partial products per axis.
    logic signed [W-1:0] a4_reg   [3];
    logic signed [W-1:0] b4_reg   [3];
    logic [2:0]          dneg4_reg;
    logic [PW-1:0]       plo4_reg [3];
    logic [PW-1:0]       phi4_reg [3];
    logic [LW-1:0]       l4_reg;
    clamp_code_t         code4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                a4_reg[i]   <= a3_reg[i];
                b4_reg[i]   <= b3_reg[i];
                plo4_reg[i] <= PW'(kmag3_reg[DW-1:0]) * PW'(dmag3_reg[i]);
                phi4_reg[i] <= PW'(kmag3_reg[LW-1:DW]) * PW'(dmag3_reg[i]);
            end
            dneg4_reg <= dneg3_reg;
            l4_reg    <= l3_reg;
            code4_reg <= code3_reg;
        end
    end

    // Divider pipeline. Entry 0 is the setup stage, entry j+1 follows step j.
    // The numerator's low bits shift out of nq as the quotient bits shift in.
    logic signed [W-1:0] da_reg   [W+1][3];
    logic signed [W-1:0] db_reg   [W+1][3];
    logic [LW-1:0]       rem_reg  [W+1][3];
    logic [W-1:0]        nq_reg   [W+1][3];
    logic [2:0]          dneg_reg [W+1];
    logic [LW-1:0]       dl_reg   [W+1];
    clamp_code_t         dcode_reg[W+1];

    logic [NW-1:0] num5 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num5[i] = NW'(plo4_reg[i]) + (NW'(phi4_reg[i]) << DW);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DIV-1]) begin
            for (int i = 0; i < 3; i++) begin
                da_reg[0][i]  <= a4_reg[i];
                db_reg[0][i]  <= b4_reg[i];
                rem_reg[0][i] <= num5[i][NW-2:W];
                nq_reg[0][i]  <= num5[i][W-1:0];
            end
            dneg_reg[0]  <= dneg4_reg;
            dl_reg[0]    <= l4_reg;
            dcode_reg[0] <= code4_reg;
        end
    end

    for (genvar j = 0; j < W; j++) begin : g_div
        logic [LW:0]   trial [3];
        logic [2:0]    fits;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = {rem_reg[j][i], nq_reg[j][i][W-1]};
                fits[i]  = trial[i] >= {1'b0, dl_reg[j]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en[DIV+j]) begin
                for (int i = 0; i < 3; i++) begin
                    da_reg[j+1][i]  <= da_reg[j][i];
                    db_reg[j+1][i]  <= db_reg[j][i];
                    rem_reg[j+1][i] <= fits[i] ? LW'(trial[i] - {1'b0, dl_reg[j]})
                                               : trial[i][LW-1:0];
                    nq_reg[j+1][i]  <= {nq_reg[j][i][W-2:0], fits[i]};
                end
                dneg_reg[j+1]  <= dneg_reg[j];
                dl_reg[j+1]    <= dl_reg[j];
                dcode_reg[j+1] <= dcode_reg[j];
            end
        end
    end

    // Output stage: select A, B or A +/- quotient.
    logic signed [W-1:0] near_reg [3];
    clamp_code_t         code_reg;

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            for (int i = 0; i < 3; i++) begin
                unique case (dcode_reg[W])
                    CLAMP_INTERIOR: near_reg[i] <= dneg_reg[W][i]
                        ? da_reg[W][i] - $signed(nq_reg[W][i])
                        : da_reg[W][i] + $signed(nq_reg[W][i]);
                    CLAMP_END:      near_reg[i] <= db_reg[W][i];
                    default:        near_reg[i] <= da_reg[W][i];
                endcase
            end
            code_reg <= dcode_reg[W];
        end
    end

    assign m_near_x     = near_reg[0];
    assign m_near_y     = near_reg[1];
    assign m_near_z     = near_reg[2];
    assign m_clamp_code = code_reg;

    // The block only refuses an item when a result is waiting downstream.
    a_ready_only_when_blocked : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    // An interior item enters the divider with a partial remainder below L.
    a_div_setup_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DIV-1] && dcode_reg[0] == CLAMP_INTERIOR)
            |-> (rem_reg[0][0] < dl_reg[0] && rem_reg[0][1] < dl_reg[0]
                 && rem_reg[0][2] < dl_reg[0]))
        else $error("divider setup remainder out of range");

    // The final remainder of an interior item stays below L.
    a_div_final_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NS-2] && dcode_reg[W] == CLAMP_INTERIOR)
            |-> (rem_reg[W][0] < dl_reg[W] && rem_reg[W][1] < dl_reg[W]
                 && rem_reg[W][2] < dl_reg[W]))
        else $error("divider final remainder out of range");

endmodule

// ----- tb/closest_point_on_segment_unit_test.sv -----
// Self-checking testbench for the closest point on segment unit.
`timescale 1ns / 100ps

module closest_point_on_segment_unit_test;
    import cps_pkg::*;

    localparam int CB = 32;
    localparam int LATENCY = CB + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1630;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t ax, ay, az, bx, by, bz, px, py, pz;
    } query_item_t;

    typedef struct packed {
        coord_t nx, ny, nz;
        clamp_code_t code;
    } near_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_start_x = '0, s_start_y = '0, s_start_z = '0;
    coord_t s_end_x = '0, s_end_y = '0, s_end_z = '0;
    coord_t s_query_x = '0, s_query_y = '0, s_query_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    coord_t m_near_x, m_near_y, m_near_z;
    logic [1:0] m_clamp_code;

    closest_point_on_segment_unit #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z),
        .s_query_x(s_query_x), .s_query_y(s_query_y), .s_query_z(s_query_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_near_x(m_near_x), .m_near_y(m_near_y), .m_near_z(m_near_z),
        .m_clamp_code(m_clamp_code)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    query_item_t pending_q[$];
    near_item_t  expected_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit drain_pause = 0;
    bit hold_off = 0;

    // Exact projection: products need 66 bits, sums 68, k*|d| about 101.
    function automatic near_item_t nearest_point(query_item_t it);
        logic signed [CB:0] d[3], v[3];
        logic signed [71:0] k, len;
        logic [139:0] num, q;
        coord_t a[3], b[3], p[3], r[3];
        near_item_t o;
        a = '{it.ax, it.ay, it.az};
        b = '{it.bx, it.by, it.bz};
        p = '{it.px, it.py, it.pz};
        k = 0;
        len = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = b[i] - a[i];
            v[i] = p[i] - a[i];
            k += d[i] * v[i];
            len += d[i] * d[i];
        end
        if (len == 0) begin
            r = a;
            o.code = CLAMP_DEGEN;
        end else if (k <= 0) begin
            r = a;
            o.code = CLAMP_START;
        end else if (k >= len) begin
            r = b;
            o.code = CLAMP_END;
        end else begin
            o.code = CLAMP_INTERIOR;
            for (int i = 0; i < 3; i++) begin
                num = 140'(k) * 140'(d[i] < 0 ? -d[i] : d[i]);
                q = num / 140'(len);
                r[i] = d[i] < 0 ? coord_t'(a[i] - q[CB:0]) : coord_t'(a[i] + q[CB:0]);
            end
        end
        o.nx = r[0];
        o.ny = r[1];
        o.nz = r[2];
        return o;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return coord_t'($urandom_range(0, 64)) - 32;
            3, 4: return coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic query_item_t rand_query();
        query_item_t it;
        it = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(0, 11))
            0: {it.bx, it.by, it.bz} = {it.ax, it.ay, it.az};
            1: {it.px, it.py, it.pz} = {it.ax, it.ay, it.az};
            2: {it.px, it.py, it.pz} = {it.bx, it.by, it.bz};
            3: begin
                // Query close to the midpoint, so the interior case is common.
                it.px = coord_t'(({it.ax[CB-1], it.ax} + {it.bx[CB-1], it.bx}) >>> 1);
                it.py = coord_t'(({it.ay[CB-1], it.ay} + {it.by[CB-1], it.by}) >>> 1);
                it.pz = coord_t'(({it.az[CB-1], it.az} + {it.bz[CB-1], it.bz}) >>> 1);
            end
            default: ;
        endcase
        return it;
    endfunction

    // Driver: bursts of random length with random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_q.push_back(nearest_point(pending_q.pop_front()));
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() == 0 || drain_pause) begin
                    s_valid <= 1'b0;
                end else if (s_valid && s_ready && pending_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    {s_start_x, s_start_y, s_start_z, s_end_x, s_end_y, s_end_z,
                     s_query_x, s_query_y, s_query_z} <= pending_q[0];
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when asked.
    int stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase <= (stall_phase + 1) % 64;
        if (hold_off) m_ready <= 1'b0;
        else if (stall_phase < 24) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 2) != 0);
    end

    // Monitor.
    always @(posedge aclk) begin
        near_item_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            got = {m_near_x, m_near_y, m_near_z, clamp_code_t'(m_clamp_code)};
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $write("Mismatch: expected x=%h y=%h z=%h code=%0d,",
                               want.nx, want.ny, want.nz, want.code);
                        $display(" got x=%h y=%h z=%h code=%0d",
                                 got.nx, got.ny, got.nz, got.code);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        query_item_t it;
        coord_t mx, mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        // Directed: degenerate, both clamps, interior, extremes.
        pending_q.push_back({9{coord_t'(0)}});
        pending_q.push_back({mx, mx, mx, mx, mx, mx, mn, mn, mn});
        pending_q.push_back({mn, mn, mn, mx, mx, mx, mn, mn, mn});
        pending_q.push_back({mn, mn, mn, mx, mx, mx, mx, mx, mx});
        pending_q.push_back({mn, mn, mn, mx, mx, mx, coord_t'(0), coord_t'(0), coord_t'(0)});
        pending_q.push_back({mx, mn, mx, mn, mx, mn, mx, mx, mn});
        pending_q.push_back({mn, mn, mn, mx, mx, mx, mn, mx, mn});
        pending_q.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0,
                             32'sh0000_8000, 32'sh0005_0000, 32'sh0});
        pending_q.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0, 32'sh0,
                             32'sh0001_0000, 32'sh0, 32'sh0});
        pending_q.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0,
                             -32'sh0001_0000, 32'sh0, 32'sh0});
        pending_q.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0,
                             32'sh0002_0000, 32'sh0, 32'sh0});
        pending_q.push_back({32'sh1, 32'sh2, 32'sh3, 32'sh4, 32'sh6, 32'sh8,
                             32'sh3, -32'sh7, 32'sh9});
        pending_q.push_back({mx, mx, mx, mn, mn, mn, 32'sh1, -32'sh1, 32'sh0});
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 300; i++) pending_q.push_back(rand_query());
        // Long receiver hold-off while items keep coming.
        hold_off = 1;
        repeat (200) @(posedge aclk);
        hold_off = 0;
        for (int i = 0; i < 400; i++) pending_q.push_back(rand_query());
        wait (pending_q.size() == 0);
        // Sender pauses until everything has come back.
        drain_pause = 1;
        wait (expected_q.size() == 0 && !s_valid);
        drain_pause = 0;
        for (int i = 0; i < N_RANDOM - 700; i++) pending_q.push_back(rand_query());
        wait (pending_q.size() == 0);
        @(posedge aclk);
        wait (expected_q.size() == 0 && !s_valid);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
